// ===== rtl/rss_pkg.sv =====
package rss_pkg;

   localparam int CAPACITY = 32;
   localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W    = 6;   // fixed by the rank field; holds 0..CAPACITY

   typedef enum logic [1:0] {
      MODE_ADD    = 2'd0,
      MODE_DELETE = 2'd1,
      MODE_GET    = 2'd2,
      MODE_PRINT  = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      KIND_ELEM    = 2'd0,
      KIND_INVALID = 2'd1,
      KIND_END     = 2'd2,
      KIND_FULL    = 2'd3
   } kind_type;

   typedef struct packed {
      mode_type   mode;
      logic [5:0] rank;
      logic [7:0] element;
   } req_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] value;
      logic       last;
   } rsp_type;

   typedef enum logic [1:0] {
      CELL_HOLD   = 2'd0,
      CELL_INSERT = 2'd1,
      CELL_DELETE = 2'd2
   } cell_op_type;

   // broadcast to every cell of the chain
   typedef struct packed {
      cell_op_type      op;
      logic [IDX_W-1:0] pos;
      logic [7:0]       element;
   } cell_ctrl_type;

endpackage

// ===== rtl/rss_cell.sv =====
module rss_cell (
   input  logic                          clock,
   input  rss_pkg::cell_ctrl_type        ctrl,
   input  logic [rss_pkg::IDX_W-1:0]     cell_idx,
   input  logic [7:0]                    lower_value,
   input  logic [7:0]                    upper_value,
   output logic [7:0]                    value
);
   import rss_pkg::*;

   logic [7:0] value_ff;
   logic [7:0] value_in;

   always_comb begin
      value_in = value_ff;
      case (ctrl.op)
         CELL_INSERT: begin
            if (cell_idx > ctrl.pos) begin
               value_in = lower_value;   // shift up
            end else if (cell_idx == ctrl.pos) begin
               value_in = ctrl.element;
            end
         end
         CELL_DELETE: begin
            if (cell_idx >= ctrl.pos) begin
               value_in = upper_value;   // shift down
            end
         end
         default: begin
            value_in = value_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

// ===== rtl/ranked_sequence_store_core.sv =====
// Ranked sequence store: chain of byte cells addressed by 1-based rank.
// Timing: add/delete take effect at the accepting edge, no result; get and
//   error results are registered and appear in the cycle after the transfer.
// Throughput: one item per cycle for add/delete/get while the result slot is free;
//   print emits count+1 results, one per cycle while rsp_ready holds, blocking input.
// Reset: item count cleared, output idle; cell contents are not cleared.
module ranked_sequence_store_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  rss_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rss_pkg::rsp_type rsp_data
);
   import rss_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE  = 2'b01,
      ST_PRINT = 2'b10
   } state_type;

   state_type        state_ff,     state_in;
   logic [CNT_W-1:0] count_ff,     count_in;
   logic [CNT_W-1:0] print_idx_ff, print_idx_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff,  rsp_data_in;

   cell_ctrl_type    cell_ctrl;
   logic [7:0]       cell_value [CAPACITY];
   logic [IDX_W-1:0] rd_addr;
   logic [7:0]       rd_value;

   logic             slot_free;
   logic             req_xfer;
   logic             rank_zero;
   logic             add_ok;
   logic             ref_ok;     // rank names an existing element
   logic             store_full;
   logic [CNT_W-1:0] rank_m1;

   // ---------------------------------------------------------------------
   // Cell chain: each cell takes its neighbor's byte on insert/delete.
   // ---------------------------------------------------------------------
   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      logic [7:0] lower_value;
      logic [7:0] upper_value;
      if (g == 0) begin : g_first
         assign lower_value = cell_ctrl.element;   // never selected
      end else begin : g_mid_lo
         assign lower_value = cell_value[g-1];
      end
      if (g == CAPACITY - 1) begin : g_last
         assign upper_value = cell_value[g];       // top slot goes stale on delete
      end else begin : g_mid_hi
         assign upper_value = cell_value[g+1];
      end
      rss_cell u_cell (
         .clock       (clock),
         .ctrl        (cell_ctrl),
         .cell_idx    (IDX_W'(g)),
         .lower_value (lower_value),
         .upper_value (upper_value),
         .value       (cell_value[g])
      );
   end

   // ---------------------------------------------------------------------
   // Control
   // ---------------------------------------------------------------------
   // A result register slot is free when empty or being drained this cycle.
   assign slot_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready  = (state_ff == ST_IDLE) && slot_free;
   assign req_xfer   = req_valid && req_ready;

   assign rank_zero  = (req_data.rank == '0);
   assign add_ok     = !rank_zero && (req_data.rank <= count_ff + CNT_W'(1));
   assign ref_ok     = !rank_zero && (req_data.rank <= count_ff);
   assign store_full = (count_ff == CNT_W'(CAPACITY));
   assign rank_m1    = req_data.rank - CNT_W'(1);

   // single shared read port: print walks by index, get uses the rank
   always_comb begin
      if (state_ff == ST_PRINT) begin
         rd_addr = print_idx_ff[IDX_W-1:0];
      end else if (req_data.mode == MODE_PRINT) begin
         rd_addr = '0;
      end else begin
         rd_addr = rank_m1[IDX_W-1:0];
      end
   end
   assign rd_value = cell_value[rd_addr];

   always_comb begin
      state_in          = state_ff;
      count_in          = count_ff;
      print_idx_in      = print_idx_ff;
      rsp_valid_in      = rsp_valid_ff && !rsp_ready;
      rsp_data_in       = rsp_data_ff;
      cell_ctrl.op      = CELL_HOLD;
      cell_ctrl.pos     = rank_m1[IDX_W-1:0];
      cell_ctrl.element = req_data.element;

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               case (req_data.mode)
                  MODE_ADD: begin
                     if (!add_ok) begin
                        rsp_valid_in = 1'b1;
                        rsp_data_in  = '{kind: KIND_INVALID, value: 8'h00, last: 1'b1};
                     end else if (store_full) begin
                        rsp_valid_in = 1'b1;
                        rsp_data_in  = '{kind: KIND_FULL, value: 8'h00, last: 1'b1};
                     end else begin
                        cell_ctrl.op = CELL_INSERT;
                        count_in     = count_ff + CNT_W'(1);
                     end
                  end
                  MODE_DELETE: begin
                     if (!ref_ok) begin
                        rsp_valid_in = 1'b1;
                        rsp_data_in  = '{kind: KIND_INVALID, value: 8'h00, last: 1'b1};
                     end else begin
                        cell_ctrl.op = CELL_DELETE;
                        count_in     = count_ff - CNT_W'(1);
                     end
                  end
                  MODE_GET: begin
                     rsp_valid_in = 1'b1;
                     if (!ref_ok) begin
                        rsp_data_in = '{kind: KIND_INVALID, value: 8'h00, last: 1'b1};
                     end else begin
                        rsp_data_in = '{kind: KIND_ELEM, value: rd_value, last: 1'b1};
                     end
                  end
                  default: begin   // print
                     rsp_valid_in = 1'b1;
                     if (count_ff == '0) begin
                        rsp_data_in = '{kind: KIND_END, value: 8'h00, last: 1'b1};
                     end else begin
                        rsp_data_in  = '{kind: KIND_ELEM, value: rd_value, last: 1'b0};
                        print_idx_in = CNT_W'(1);
                        state_in     = ST_PRINT;
                     end
                  end
               endcase
            end
         end
         ST_PRINT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               if (print_idx_ff == count_ff) begin
                  rsp_data_in = '{kind: KIND_END, value: 8'h00, last: 1'b1};
                  state_in    = ST_IDLE;
               end else begin
                  rsp_data_in  = '{kind: KIND_ELEM, value: rd_value, last: 1'b0};
                  print_idx_in = print_idx_ff + CNT_W'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         print_idx_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         print_idx_ff <= print_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("item count above capacity");

   a_print_idx_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PRINT) |-> (print_idx_ff <= count_ff) && (print_idx_ff != '0))
      else $error("print index out of range");

   a_no_input_in_print: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PRINT) |-> !req_ready)
      else $error("input taken during print");

   a_count_stable_in_print: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PRINT) |=> $stable(count_ff))
      else $error("item count changed during print");

   a_nonelem_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_data_ff.kind != KIND_ELEM)) |-> (rsp_data_ff.value == 8'h00))
      else $error("non-element result carries a value");

endmodule

// ===== tb/sv/ranked_sequence_store_checker.sv =====
module ranked_sequence_store_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  rss_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  rss_pkg::rsp_type rsp_data,
   output int               mismatch_count,
   output int               awaited_count
);
   import rss_pkg::*;

   logic [7:0] seq_cells [CAPACITY];
   int         seq_len;
   rsp_type    awaited_rsp [$];
   rsp_type    want;

   function automatic void queue_result(input kind_type k, input logic [7:0] v,
                                        input logic lst);
      rsp_type r;
      r.kind  = k;
      r.value = v;
      r.last  = lst;
      awaited_rsp.push_back(r);
   endfunction

   // applies one accepted request to the shadow sequence, queues its results
   function automatic void model_sequence_op(input req_type rq);
      int i;
      int rk;
      rk = int'(rq.rank);
      case (rq.mode)
         MODE_ADD: begin
            if (rk < 1 || rk > seq_len + 1)
               queue_result(KIND_INVALID, 8'h00, 1'b1);
            else if (seq_len >= CAPACITY)
               queue_result(KIND_FULL, 8'h00, 1'b1);
            else begin
               for (i = seq_len; i >= rk; i--)
                  seq_cells[IDX_W'(i)] = seq_cells[IDX_W'(i-1)];
               seq_cells[IDX_W'(rk-1)] = rq.element;
               seq_len++;
            end
         end
         MODE_DELETE: begin
            if (rk < 1 || rk > seq_len)
               queue_result(KIND_INVALID, 8'h00, 1'b1);
            else begin
               for (i = rk; i < seq_len; i++)
                  seq_cells[IDX_W'(i-1)] = seq_cells[IDX_W'(i)];
               seq_len--;
            end
         end
         MODE_GET: begin
            if (rk < 1 || rk > seq_len)
               queue_result(KIND_INVALID, 8'h00, 1'b1);
            else
               queue_result(KIND_ELEM, seq_cells[IDX_W'(rk-1)], 1'b1);
         end
         default: begin
            for (i = 0; i < seq_len; i++)
               queue_result(KIND_ELEM, seq_cells[IDX_W'(i)], 1'b0);
            queue_result(KIND_END, 8'h00, 1'b1);
         end
      endcase
   endfunction

   // request side first: a result never leaves in the cycle of its request
   always @(posedge clock) begin
      if (reset) begin
         seq_len        = 0;
         mismatch_count = 0;
         awaited_rsp.delete();
      end else begin
         if (req_valid && req_ready)
            model_sequence_op(req_data);
         if (rsp_valid && rsp_ready) begin
            if (awaited_rsp.size() == 0) begin
               $error("unexpected result: kind %0d value %0h last %0d",
                      rsp_data.kind, rsp_data.value, rsp_data.last);
               mismatch_count++;
            end else begin
               want = awaited_rsp.pop_front();
               if (rsp_data.kind !== want.kind) begin
                  $error("kind: expected %0d, actual %0d", want.kind, rsp_data.kind);
                  mismatch_count++;
               end
               if (rsp_data.value !== want.value) begin
                  $error("value: expected %0h, actual %0h", want.value, rsp_data.value);
                  mismatch_count++;
               end
               if (rsp_data.last !== want.last) begin
                  $error("last: expected %0d, actual %0d", want.last, rsp_data.last);
                  mismatch_count++;
               end
            end
         end
      end
      awaited_count = awaited_rsp.size();
   end

endmodule

// ===== tb/sv/ranked_sequence_store_core_tb.sv =====
module ranked_sequence_store_core_tb;
   import rss_pkg::*;

   localparam int CYCLE_LIMIT     = 1_000_000;  // far above the slowest legal run
   localparam int HOLD_OFF_CYCLES = 300;        // long receiver stall, fills the block
   localparam int RANDOM_ITEMS    = 450;
   localparam int SETTLE_CYCLES   = 10;         // tail after the last result

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   int mismatch_count;
   int awaited_count;
   int cycle_count = 0;

   // idle knobs, percent of cycles
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   bit hold_request   = 1'b0;

   // stimulus-side occupancy, only used to aim ranks at the valid window
   int fill_level = 0;

   ranked_sequence_store_core u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   ranked_sequence_store_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .mismatch_count (mismatch_count),
      .awaited_count  (awaited_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Receiver: random stalls at the falling edge. A hold request parks
   // rsp_ready low for a long stretch, counted here, while the sender keeps
   // offering transfers, so prints and gets back up into req_ready.
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            repeat (HOLD_OFF_CYCLES) begin
               rsp_ready <= 1'b0;
               @(negedge clock);
            end
         end
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // One request transfer. Entered and left at a falling edge; valid stays
   // high into the next call unless an idle gap is drawn.
   task automatic offer_request(input mode_type m, input logic [5:0] r,
                                input logic [7:0] e);
      req_type item;
      item.mode    = m;
      item.rank    = r;
      item.element = e;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      // track occupancy for rank selection only
      case (m)
         MODE_ADD:
            if (r >= 1 && r <= fill_level + 1 && fill_level < CAPACITY)
               fill_level++;
         MODE_DELETE:
            if (r >= 1 && r <= fill_level)
               fill_level--;
         default: ;
      endcase
   endtask

   // sender pause: nothing offered until every queued result has come back
   task automatic wait_for_results();
      req_valid <= 1'b0;
      @(negedge clock);
      while (awaited_count != 0) @(negedge clock);
   endtask

   // mostly valid ranks, some right at the window edges, some anywhere
   function automatic logic [5:0] pick_rank(input mode_type m);
      int         top_rank;
      int         u;
      logic [5:0] r;
      top_rank = (m == MODE_ADD) ? fill_level + 1 : fill_level;
      u = $urandom_range(99);
      if (u < 80 && top_rank > 0)
         r = 6'($urandom_range(top_rank, 1));
      else if (u < 90)
         r = ($urandom_range(1) == 0) ? 6'd0 : 6'(top_rank + 1);
      else
         r = 6'($urandom_range(63));
      return r;
   endfunction

   // trend 0 grows the sequence, 1 shrinks it, 2 is balanced
   function automatic mode_type pick_mode(input int trend);
      int u;
      u = $urandom_range(99);
      case (trend)
         0:       return (u < 75) ? MODE_ADD : (u < 85) ? MODE_GET :
                         (u < 92) ? MODE_DELETE : MODE_PRINT;
         1:       return (u < 15) ? MODE_ADD : (u < 65) ? MODE_DELETE :
                         (u < 88) ? MODE_GET : MODE_PRINT;
         default: return (u < 35) ? MODE_ADD : (u < 60) ? MODE_DELETE :
                         (u < 88) ? MODE_GET : MODE_PRINT;
      endcase
   endfunction

   initial begin
      int         phase;
      int         n;
      int         trend;
      int         trend_left;
      mode_type   m;
      logic [5:0] r;
      logic [7:0] e;

      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      trend     = 2;
      trend_left = 0;
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: empty-store corner cases, window edges, extreme bytes.
      offer_request(MODE_PRINT,  6'd0,  8'h00);  // empty print: end marker only
      offer_request(MODE_GET,    6'd1,  8'h00);  // get on empty store
      offer_request(MODE_DELETE, 6'd1,  8'h00);  // delete on empty store
      offer_request(MODE_ADD,    6'd0,  8'h11);  // rank zero
      offer_request(MODE_ADD,    6'd2,  8'h22);  // one past count+1
      offer_request(MODE_ADD,    6'd1,  8'h00);  // zero byte is a real element
      offer_request(MODE_ADD,    6'd2,  8'hFF);  // append
      offer_request(MODE_ADD,    6'd1,  8'hA5);  // insert at head
      offer_request(MODE_ADD,    6'd4,  8'h5A);  // append at count+1
      offer_request(MODE_ADD,    6'd6,  8'h33);  // beyond count+1
      offer_request(MODE_GET,    6'd1,  8'h00);
      offer_request(MODE_GET,    6'd4,  8'h00);
      offer_request(MODE_GET,    6'd5,  8'h00);  // one past count
      offer_request(MODE_GET,    6'd63, 8'hFF);  // top of rank field
      offer_request(MODE_GET,    6'd0,  8'h00);
      offer_request(MODE_DELETE, 6'd0,  8'h00);
      offer_request(MODE_DELETE, 6'd5,  8'h00);
      offer_request(MODE_DELETE, 6'd2,  8'h00);  // middle delete
      offer_request(MODE_PRINT,  6'd63, 8'hFF);  // rank ignored by print
      offer_request(MODE_DELETE, 6'd3,  8'h00);  // tail delete
      offer_request(MODE_DELETE, 6'd1,  8'h00);  // head delete
      offer_request(MODE_PRINT,  6'd0,  8'h00);
      offer_request(MODE_DELETE, 6'd1,  8'h00);  // back to empty
      offer_request(MODE_PRINT,  6'd0,  8'h00);
      wait_for_results();

      // Random: receiver-heavy stalling, then sender-heavy idling, then none.
      for (phase = 0; phase < 3; phase++) begin
         case (phase)
            0:       begin send_idle_pct = 8;  recv_stall_pct = 80; end
            1:       begin send_idle_pct = 80; recv_stall_pct = 8;  end
            default: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
         endcase
         if (phase == 2)
            hold_request = 1'b1;
         for (n = 0; n < RANDOM_ITEMS / 3; n++) begin
            e = 8'($urandom_range(255));
            if (phase == 0 && n < 34) begin
               // fill to capacity with valid ranks; last two adds hit full
               m = MODE_ADD;
               r = 6'($urandom_range(fill_level + 1, 1));
            end else begin
               if (trend_left == 0) begin
                  trend      = $urandom_range(2);
                  trend_left = $urandom_range(60, 20);
               end
               trend_left--;
               m = pick_mode(trend);
               r = pick_rank(m);
            end
            offer_request(m, r, e);
         end
         wait_for_results();
      end

      // stray results after the last expected one are flagged by the checker
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (mismatch_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
